FILE: hw/rtl/rrf_pkg.sv
// ----------------------------------------------------------------------------
// rrf_pkg
// Shared constants, register indexes and types of the rolling fingerprint.
// ----------------------------------------------------------------------------
package rrf_pkg;

    localparam int unsigned WINDOW_MAX_DEF = 64;
    localparam int unsigned PRINT_W        = 64;
    localparam int unsigned BYTE_W         = 8;
    localparam int unsigned WSIZE_W        = 7;
    localparam int unsigned DEG_W          = 6;
    localparam int unsigned CFG_INDEX_W    = 2;
    localparam int unsigned PIPE_DEPTH     = 3;

    localparam logic [PRINT_W-1:0] POLY_RESET  = 64'hBFE6_B8A5_BF37_8D83;
    localparam logic [PRINT_W-1:0] POLY_MIN    = 64'd256;
    localparam logic [WSIZE_W-1:0] WSIZE_RESET = 7'd48;

    localparam logic [CFG_INDEX_W-1:0] REG_POLY  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WSIZE = 2'd1;

    typedef enum logic [2:0] {
        BLD_START,
        BLD_RED,
        BLD_WEIGHT,
        BLD_WGT,
        BLD_RUN
    } bld_state_t;

    // basis rows: entry j is the table value for the byte with only bit j set
    typedef struct packed {
        logic [BYTE_W-1:0][PRINT_W-1:0] red;
        logic [BYTE_W-1:0][PRINT_W-1:0] wgt;
        logic [DEG_W-1:0]               top_shift;
    } tables_t;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] old_byte;
        logic [BYTE_W-1:0] data_byte;
    } stage1_t;

endpackage

FILE: hw/rtl/rrf_build.sv
// ----------------------------------------------------------------------------
// rrf_build
// Configuration registers and the table build sequencer. Derives the
// reduction and outgoing-byte basis rows one multiply-by-x step per cycle.
// ----------------------------------------------------------------------------
module rrf_build #(
    parameter int unsigned WINDOW_MAX = rrf_pkg::WINDOW_MAX_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [rrf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [rrf_pkg::PRINT_W-1:0]        cfg_wdata,
    output rrf_pkg::tables_t                   tables,
    output logic [$clog2(WINDOW_MAX+1)-1:0]    eff_window,
    output logic                               busy
);
    import rrf_pkg::*;

    localparam int unsigned WIN_W  = $clog2(WINDOW_MAX + 1);
    localparam int unsigned CMP_W  = (WIN_W > WSIZE_W) ? WIN_W : WSIZE_W;
    localparam int unsigned STEP_W = WIN_W + 3;
    localparam logic [CMP_W-1:0] WIN_LIMIT = CMP_W'(WINDOW_MAX);

    function automatic logic [DEG_W-1:0] poly_degree(input logic [PRINT_W-1:0] v);
        logic [DEG_W-1:0] d;
        d = '0;
        for (int i = 0; i < PRINT_W; i++) begin
            if (v[i]) d = DEG_W'(i);
        end
        return d;
    endfunction

    function automatic logic [PRINT_W-1:0] times_x(
        input logic [PRINT_W-1:0] r,
        input logic [PRINT_W-1:0] p,
        input logic [DEG_W-1:0]   d
    );
        logic [PRINT_W-1:0] s;
        s = {r[PRINT_W-2:0], 1'b0};
        if (s[d]) s = s ^ p;
        return s;
    endfunction

    bld_state_t state_reg, state_next;

    logic [PRINT_W-1:0]             poly_reg;
    logic [WSIZE_W-1:0]             wsize_reg;
    logic [PRINT_W-1:0]             eff_poly_reg;
    logic [DEG_W-1:0]               deg_reg;
    logic [DEG_W-1:0]               top_shift_reg;
    logic [WIN_W-1:0]               win_reg;
    logic [PRINT_W-1:0]             acc_reg;
    logic [2:0]                     idx_reg;
    logic [STEP_W-1:0]              step_reg;
    logic [BYTE_W-1:0][PRINT_W-1:0] red_reg;
    logic [BYTE_W-1:0][PRINT_W-1:0] wgt_reg;

    logic                 cfg_hit;
    logic [PRINT_W-1:0]   eff_poly_c;
    logic [DEG_W-1:0]     deg_c;
    logic [CMP_W-1:0]     wsize_ext;
    logic [CMP_W-1:0]     win_c;
    logic [PRINT_W-1:0]   acc_step;
    logic [PRINT_W-1:0]   red_bit;

    assign cfg_hit = cfg_wr_en && (cfg_index == REG_POLY || cfg_index == REG_WSIZE);

    always_comb begin
        eff_poly_c = (poly_reg < POLY_MIN) ? POLY_RESET : poly_reg;
        deg_c      = poly_degree(eff_poly_c);
        wsize_ext  = CMP_W'(wsize_reg);
        if (wsize_reg == '0) begin
            win_c = CMP_W'(1);
        end else if (wsize_ext > WIN_LIMIT) begin
            win_c = WIN_LIMIT;
        end else begin
            win_c = wsize_ext;
        end
        acc_step = times_x(acc_reg, eff_poly_reg, deg_reg);
        // the top-byte bit of the reduce row, gone when it falls past bit 63
        red_bit  = PRINT_W'(1) << ((DEG_W+1)'(deg_reg) + (DEG_W+1)'(idx_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poly_reg  <= POLY_RESET;
            wsize_reg <= WSIZE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_POLY:  poly_reg  <= cfg_wdata;
                REG_WSIZE: wsize_reg <= cfg_wdata[WSIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BLD_START;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        busy       = (state_reg != BLD_RUN);
        unique case (state_reg)
            BLD_START:  state_next = BLD_RED;
            BLD_RED:    if (idx_reg == '1) state_next = BLD_WEIGHT;
            BLD_WEIGHT: if (step_reg == '0) state_next = BLD_WGT;
            BLD_WGT:    if (idx_reg == '1) state_next = BLD_RUN;
            BLD_RUN:    state_next = BLD_RUN;
            default:    state_next = BLD_START;
        endcase
        if (cfg_hit) state_next = BLD_START;
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            BLD_START: begin
                eff_poly_reg  <= eff_poly_c;
                deg_reg       <= deg_c;
                top_shift_reg <= deg_c - DEG_W'(BYTE_W);
                win_reg       <= win_c[WIN_W-1:0];
                acc_reg       <= eff_poly_c ^ (PRINT_W'(1) << deg_c);
                idx_reg       <= '0;
            end
            BLD_RED: begin
                red_reg[idx_reg] <= acc_reg | red_bit;
                idx_reg          <= idx_reg + 3'd1;
                if (idx_reg == '1) begin
                    // position weight starts at one, then x^8 per extra byte
                    acc_reg  <= PRINT_W'(1);
                    step_reg <= {win_reg - WIN_W'(1), 3'b000};
                end else begin
                    acc_reg <= acc_step;
                end
            end
            BLD_WEIGHT: begin
                if (step_reg != '0) begin
                    acc_reg  <= acc_step;
                    step_reg <= step_reg - STEP_W'(1);
                end
            end
            BLD_WGT: begin
                wgt_reg[idx_reg] <= acc_reg;
                acc_reg          <= acc_step;
                idx_reg          <= idx_reg + 3'd1;
            end
            default: ;
        endcase
    end

    always_comb begin
        tables.red       = red_reg;
        tables.wgt       = wgt_reg;
        tables.top_shift = top_shift_reg;
    end

    assign eff_window = win_reg;

endmodule

FILE: hw/rtl/rrf_window.sv
// ----------------------------------------------------------------------------
// rrf_window
// Byte ring memory with the write position. Reads the outgoing byte and
// writes the incoming one in the same cycle; a fill flag masks slots not yet
// written since the last restart.
// ----------------------------------------------------------------------------
module rrf_window #(
    parameter int unsigned WINDOW_MAX = rrf_pkg::WINDOW_MAX_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               clear,
    input  logic                               accept,
    input  logic                               load,
    input  logic [rrf_pkg::BYTE_W-1:0]         data_byte,
    input  logic [$clog2(WINDOW_MAX+1)-1:0]    eff_window,
    output rrf_pkg::stage1_t                   s1
);
    import rrf_pkg::*;

    localparam int unsigned WIN_W = $clog2(WINDOW_MAX + 1);
    localparam int unsigned POS_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

    logic [BYTE_W-1:0] ring_mem [WINDOW_MAX];

    logic [POS_W-1:0]  pos_reg;
    logic              full_reg;
    logic [BYTE_W-1:0] rd_reg;
    logic              fill1_reg;
    logic [BYTE_W-1:0] m1_reg;
    logic              v1_reg;

    logic [WIN_W-1:0]  pos_inc;
    logic              wrap;

    assign pos_inc = WIN_W'(pos_reg) + WIN_W'(1);
    assign wrap    = (pos_inc >= eff_window);

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            pos_reg  <= '0;
            full_reg <= 1'b0;
        end else if (accept) begin
            if (wrap) begin
                pos_reg  <= '0;
                full_reg <= 1'b1;
            end else begin
                pos_reg <= pos_inc[POS_W-1:0];
            end
        end
    end

    // read-first: the registered read returns the byte being replaced
    always_ff @(posedge aclk) begin
        if (accept) begin
            ring_mem[pos_reg] <= data_byte;
        end
        if (load) begin
            rd_reg    <= ring_mem[pos_reg];
            fill1_reg <= full_reg;
            m1_reg    <= data_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (load) begin
            v1_reg <= accept;
        end
    end

    always_comb begin
        s1.valid     = v1_reg;
        s1.old_byte  = rd_reg & {BYTE_W{fill1_reg}};
        s1.data_byte = m1_reg;
    end

endmodule

FILE: hw/rtl/rrf_fold.sv
// ----------------------------------------------------------------------------
// rrf_fold
// Cancels the outgoing byte, then shifts in the new byte and reduces. Holds
// the running fingerprint, which is also the output register.
// ----------------------------------------------------------------------------
module rrf_fold (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        clear,
    input  rrf_pkg::tables_t            tables,
    input  rrf_pkg::stage1_t            s1,
    output logic                        s1_load,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [rrf_pkg::PRINT_W-1:0] m_fingerprint
);
    import rrf_pkg::*;

    logic               v2_reg;
    logic [PRINT_W-1:0] og_reg;
    logic [BYTE_W-1:0]  m2_reg;
    logic               v3_reg;
    logic [PRINT_W-1:0] print_reg;
    logic [PRINT_W-1:0] print_next;

    logic               adv3;
    logic               en2;
    logic [PRINT_W-1:0] og_c;
    logic [PRINT_W-1:0] q_c;
    logic [PRINT_W-1:0] q_shift;
    logic [BYTE_W-1:0]  top_byte;
    logic [PRINT_W-1:0] red_c;

    assign adv3    = v2_reg && (!v3_reg || m_ready);
    assign en2     = !v2_reg || adv3;
    assign s1_load = !s1.valid || en2;

    always_comb begin
        og_c = '0;
        for (int j = 0; j < BYTE_W; j++) begin
            if (s1.old_byte[j]) og_c = og_c ^ tables.wgt[j];
        end
    end

    always_comb begin
        q_c      = print_reg ^ og_reg;
        q_shift  = q_c >> tables.top_shift;
        top_byte = q_shift[BYTE_W-1:0];
        red_c    = '0;
        for (int j = 0; j < BYTE_W; j++) begin
            if (top_byte[j]) red_c = red_c ^ tables.red[j];
        end
        print_next = {q_c[PRINT_W-BYTE_W-1:0], m2_reg} ^ red_c;
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            og_reg <= og_c;
            m2_reg <= s1.data_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en2) v2_reg <= s1.valid;
            if (adv3) begin
                v3_reg <= 1'b1;
            end else if (m_ready) begin
                v3_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            print_reg <= '0;
        end else if (adv3) begin
            print_reg <= print_next;
        end
    end

    assign m_valid       = v3_reg;
    assign m_fingerprint = print_reg;

endmodule

FILE: hw/rtl/rabin_rolling_fingerprint_top.sv
// ----------------------------------------------------------------------------
// rabin_rolling_fingerprint_top
// Rolling fingerprint mod a binary polynomial over a sliding byte window.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while no table rebuild runs and the stages have room,
// and returns one 64-bit fingerprint per byte; each byte passes the window,
// cancel and fingerprint registers before m_valid rises; a result waiting on
// m_ready does not stop new bytes until the three stages are full. The window
// bytes sit in a ring memory read and written in the same cycle. After reset
// and after every write to poly or the window length register the block
// rebuilds its reduction tables with a single multiply-by-x unit, one step per
// cycle, and holds s_ready low while it does; the stream then restarts from an
// all-zero window.
module rabin_rolling_fingerprint_top #(
    parameter int unsigned WINDOW_MAX = rrf_pkg::WINDOW_MAX_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [rrf_pkg::BYTE_W-1:0]      s_data_byte,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [rrf_pkg::PRINT_W-1:0]     m_fingerprint,
    input  logic                            cfg_wr_en,
    input  logic [rrf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rrf_pkg::PRINT_W-1:0]     cfg_wdata
);
    import rrf_pkg::*;

    localparam int unsigned WIN_W = $clog2(WINDOW_MAX + 1);

    tables_t          tables;
    stage1_t          s1;
    logic [WIN_W-1:0] eff_window;
    logic             busy;
    logic             s1_load;
    logic             s_accept;

    assign s_ready  = s1_load && !busy;
    assign s_accept = s_valid && s_ready;

    rrf_build #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_build (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .tables     (tables),
        .eff_window (eff_window),
        .busy       (busy)
    );

    rrf_window #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_window (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .clear      (busy),
        .accept     (s_accept),
        .load       (s1_load),
        .data_byte  (s_data_byte),
        .eff_window (eff_window),
        .s1         (s1)
    );

    rrf_fold u_fold (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .clear         (busy),
        .tables        (tables),
        .s1            (s1),
        .s1_load       (s1_load),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_fingerprint (m_fingerprint)
    );

endmodule

FILE: hw/rtl/rrf_checker.sv
// ----------------------------------------------------------------------------
// rrf_port_checks
// Port-level checks of the rolling fingerprint block, bound to the top level.
// ----------------------------------------------------------------------------
module rrf_port_checks (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [rrf_pkg::PRINT_W-1:0]     m_fingerprint,
    input logic                            cfg_wr_en,
    input logic [rrf_pkg::CFG_INDEX_W-1:0] cfg_index
);
    import rrf_pkg::*;

    logic [2:0] pending_reg;
    logic [2:0] pending_next;
    logic       in_xfer;
    logic       out_xfer;
    logic       cfg_hit;

    assign in_xfer  = s_valid && s_ready;
    assign out_xfer = m_valid && m_ready;
    assign cfg_hit  = cfg_wr_en && (cfg_index == REG_POLY || cfg_index == REG_WSIZE);

    always_comb begin
        pending_next = pending_reg + 3'(in_xfer) - 3'(out_xfer);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_fingerprint))
        else $error("result changed while stalled");

    // register write starts a table rebuild, input closed
    a_cfg_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_hit |=> !s_ready ##1 !s_ready)
        else $error("input open during table rebuild");

    // no more bytes in flight than pipeline stages
    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg <= 3'(PIPE_DEPTH))
        else $error("too many bytes in flight");

    // every result comes from a transferred byte
    a_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pending_reg != '0)
        else $error("result without input byte");

endmodule

bind rabin_rolling_fingerprint_top rrf_port_checks u_port_checks (.*);

FILE: sim/rrf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrf_checker
// Watches the byte and fingerprint channels and the register port, keeps its
// own rolling fingerprint state and compares every returned fingerprint with
// the oldest one predicted.
// ----------------------------------------------------------------------------
module rrf_checker
    import rrf_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  logic [BYTE_W-1:0]      s_data_byte,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  logic [PRINT_W-1:0]     m_fingerprint,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [PRINT_W-1:0]     cfg_wdata,
    output int unsigned            fail_count,
    output int unsigned            pending_prints,
    output int unsigned            prints_checked
);

    logic [PRINT_W-1:0] cfg_poly;
    logic [WSIZE_W-1:0] cfg_wsize;
    logic [PRINT_W-1:0] eff_poly;
    int unsigned        poly_deg;
    int unsigned        win_len;
    int unsigned        next_slot;
    logic [PRINT_W-1:0] cur_print;
    logic [PRINT_W-1:0] want_print;
    logic [BYTE_W-1:0]  ring [WINDOW_MAX_DEF];
    logic [PRINT_W-1:0] reduce_rows [256];
    logic [PRINT_W-1:0] leaving_rows [256];
    logic [PRINT_W-1:0] expected_prints [$];

    initial begin
        fail_count     = 0;
        prints_checked = 0;
        pending_prints = 0;
    end

    function automatic logic [PRINT_W-1:0] times_x_mod(input logic [PRINT_W-1:0] r);
        logic [PRINT_W-1:0] s;
        s = r << 1;
        if (s[poly_deg]) begin
            s = s ^ eff_poly;
        end
        return s;
    endfunction

    function automatic logic [PRINT_W-1:0] poly_mul_mod(input logic [PRINT_W-1:0] a,
                                                        input logic [PRINT_W-1:0] b);
        logic [PRINT_W-1:0] r;
        int k;
        r = '0;
        for (k = PRINT_W - 1; k >= 0; k--) begin
            r = times_x_mod(r);
            if (a[k]) begin
                r = r ^ b;
            end
        end
        return r;
    endfunction

    function automatic logic [PRINT_W-1:0] shift_in_byte(input logic [PRINT_W-1:0] p,
                                                         input logic [BYTE_W-1:0] m);
        logic [PRINT_W-1:0] lead;
        lead = p >> (poly_deg - BYTE_W);
        return ((p << BYTE_W) | {56'd0, m}) ^ reduce_rows[lead[BYTE_W-1:0]];
    endfunction

    // tables follow the registers, and any rebuild restarts the stream
    task automatic rebuild_tables();
        logic [PRINT_W-1:0] xk;
        logic [PRINT_W-1:0] weight;
        logic [PRINT_W-1:0] idx64;
        int i;
        eff_poly = (cfg_poly < POLY_MIN) ? POLY_RESET : cfg_poly;
        poly_deg = 0;
        for (i = 0; i < PRINT_W; i++) begin
            if (eff_poly[i]) begin
                poly_deg = i;
            end
        end
        if (cfg_wsize == 0) begin
            win_len = 1;
        end else if (cfg_wsize > WINDOW_MAX_DEF) begin
            win_len = WINDOW_MAX_DEF;
        end else begin
            win_len = cfg_wsize;
        end
        xk = eff_poly ^ (64'd1 << poly_deg);
        for (i = 0; i < 256; i++) begin
            idx64 = PRINT_W'(i);
            reduce_rows[i] = poly_mul_mod(idx64, xk) | (idx64 << poly_deg);
        end
        weight = 64'd1;
        for (i = 1; i < win_len; i++) begin
            weight = shift_in_byte(weight, 8'd0);
        end
        for (i = 0; i < 256; i++) begin
            idx64 = PRINT_W'(i);
            leaving_rows[i] = poly_mul_mod(idx64, weight);
        end
        for (i = 0; i < WINDOW_MAX_DEF; i++) begin
            ring[i] = '0;
        end
        next_slot = 0;
        cur_print = '0;
    endtask

    task automatic hash_byte(input logic [BYTE_W-1:0] m);
        int unsigned       slot;
        logic [BYTE_W-1:0] oldest;
        slot = next_slot;
        if (slot >= win_len || slot >= WINDOW_MAX_DEF) begin
            slot = 0;
        end
        oldest     = ring[slot];
        ring[slot] = m;
        next_slot  = (slot + 1 >= win_len) ? 0 : slot + 1;
        cur_print  = shift_in_byte(cur_print ^ leaving_rows[oldest], m);
        expected_prints.push_back(cur_print);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_poly  = POLY_RESET;
            cfg_wsize = WSIZE_RESET;
            rebuild_tables();
            expected_prints.delete();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == REG_POLY) begin
                    cfg_poly = cfg_wdata;
                    rebuild_tables();
                end else if (cfg_index == REG_WSIZE) begin
                    cfg_wsize = cfg_wdata[WSIZE_W-1:0];
                    rebuild_tables();
                end
            end
            if (s_valid && s_ready) begin
                hash_byte(s_data_byte);
            end
            if (m_valid && m_ready) begin
                if (expected_prints.size() == 0) begin
                    fail_count++;
                    $display("%0t: fingerprint %h transferred with none expected",
                             $time, m_fingerprint);
                end else begin
                    want_print = expected_prints.pop_front();
                    prints_checked++;
                    if (m_fingerprint !== want_print) begin
                        fail_count++;
                        $display("%0t: fingerprint mismatch, expected %h, actual %h",
                                 $time, want_print, m_fingerprint);
                    end
                end
            end
        end
        pending_prints <= expected_prints.size();
    end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Byte stream stimulus and verdict for the rolling fingerprint block.
// ----------------------------------------------------------------------------
// Runs a short corner-byte sequence, then random byte streams under a series
// of polynomial and window settings (degree 8 and 63, out-of-range and
// ignored register writes), with random idling on both channels but in phase 2.
// ----------------------------------------------------------------------------
module tb_top;
    import rrf_pkg::*;

    localparam int NUM_PHASES      = 16;
    localparam int BYTES_PER_PHASE = 102;
    localparam int STALL_LIMIT     = 5000;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

    logic                   aclk        = 1'b0;
    logic                   aresetn     = 1'b0;
    logic                   s_valid     = 1'b0;
    logic                   s_ready;
    logic [BYTE_W-1:0]      s_data_byte = '0;
    logic                   m_valid;
    logic                   m_ready     = 1'b0;
    logic [PRINT_W-1:0]     m_fingerprint;
    logic                   cfg_wr_en   = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index   = '0;
    logic [PRINT_W-1:0]     cfg_wdata   = '0;
    logic                   idle_en     = 1'b1;

    int unsigned fail_count;
    int unsigned pending_prints;
    int unsigned prints_checked;
    int unsigned bytes_sent  = 0;
    int unsigned stall_count = 0;

    logic [BYTE_W-1:0] corner_bytes [16] = '{
        8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h55, 8'hAA,
        8'h00, 8'h00, 8'hFF, 8'hFF, 8'h0F, 8'hF0, 8'h33, 8'hCC
    };

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    rabin_rolling_fingerprint_top DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_fingerprint (m_fingerprint),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    rrf_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_fingerprint  (m_fingerprint),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .fail_count     (fail_count),
        .pending_prints (pending_prints),
        .prints_checked (prints_checked)
    );

    always @(posedge aclk) begin
        m_ready <= idle_en ? ($urandom_range(0, 99) >= 22) : 1'b1;
    end

    // no transfer for too long means a hang
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            stall_count <= 0;
        end else begin
            stall_count <= stall_count + 1;
        end
        if (stall_count == STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while (idle_en && $urandom_range(0, 99) < 22) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_prints != 0);
    endtask

    // leaves the write enable high, the caller lowers it after the last write
    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [PRINT_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    initial begin
        int ph;
        int n;
        int deg;
        logic [PRINT_W-1:0] wd;
        logic [BYTE_W-1:0]  b;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph > 0) begin
                wait_drained();
                case (ph)
                    1: begin
                        cfg_write(REG_POLY, 64'h11B);
                        cfg_write(REG_WSIZE, 64'd1);
                    end
                    2: begin
                        cfg_write(REG_POLY, '1);
                        cfg_write(REG_WSIZE, 64'd64);
                    end
                    3: begin
                        cfg_write(REG_POLY, 64'd0);
                        cfg_write(REG_WSIZE, 64'd0);
                    end
                    4: begin
                        cfg_write(REG_POLY, 64'd255);
                        cfg_write(REG_WSIZE, '1);
                    end
                    5: begin
                        cfg_write(REG_POLY, 64'h100);
                        cfg_write(REG_WSIZE, 64'd65);
                    end
                    6: begin
                        // unused indexes, stream carries on
                        cfg_write(REG_SPARE_A, {$urandom, $urandom});
                        cfg_write(REG_SPARE_B, '1);
                    end
                    7: begin
                        cfg_write(REG_POLY, 64'h8000_0000_0000_0001);
                        cfg_write(REG_WSIZE, 64'd2);
                    end
                    8: begin
                        cfg_write(REG_WSIZE, 64'd47);
                    end
                    default: begin
                        deg = $urandom_range(8, 63);
                        wd  = {$urandom, $urandom};
                        wd  = (wd & ((64'd1 << deg) - 64'd1)) | (64'd1 << deg);
                        cfg_write(REG_POLY, wd);
                        if (ph % 3 != 0) begin
                            wd = {$urandom, $urandom};
                            if ($urandom_range(0, 3) != 0) begin
                                wd[WSIZE_W-1:0] = WSIZE_W'($urandom_range(1, 64));
                            end
                            cfg_write(REG_WSIZE, wd);
                        end
                    end
                endcase
                cfg_wr_en <= 1'b0;
            end
            idle_en <= (ph != 2);
            if (ph == 0) begin
                for (n = 0; n < 16; n++) begin
                    send_byte(corner_bytes[n]);
                end
            end
            for (n = 0; n < BYTES_PER_PHASE; n++) begin
                if (ph == 9 && n == 50) begin
                    wait_drained();
                end
                if ($urandom_range(0, 7) == 0) begin
                    b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                end else begin
                    b = BYTE_W'($urandom_range(0, 255));
                end
                send_byte(b);
            end
        end

        wait_drained();
        repeat (4 * PIPE_DEPTH) @(posedge aclk);

        if (pending_prints != 0) begin
            $display("%0t: %0d fingerprints never transferred", $time, pending_prints);
        end
        $display("%0d bytes hashed over %0d phases, %0d fingerprints checked",
                 bytes_sent, NUM_PHASES, prints_checked);
        $display("polynomials of degree 8 to 63 and below 256, windows 1 to 64 and clamped");
        if (fail_count == 0 && pending_prints == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
